>>> design/hopping_chirp_fsk_modulator_top_defines.svh
// Assertion macros used by the hopping chirp FSK modulator top level.
`ifndef HOPPING_CHIRP_FSK_MODULATOR_TOP_DEFINES_SVH
`define HOPPING_CHIRP_FSK_MODULATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define HCFM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define HCFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/hcfm_pkg.sv
// Types, constants, microprogram and sine table function of the chirp FSK modulator.
package hcfm_pkg;

	localparam int SPB_MAX             = 255;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 18;
	localparam int SAMPLE_W    = 12;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPACE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MARK  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FS    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPB   = 8'd3;

	localparam logic [14:0] SPACE_RESET = 15'd6400;
	localparam logic [14:0] MARK_RESET  = 15'd8800;
	localparam logic [17:0] FS_RESET    = 18'd44100;
	localparam logic [7:0]  SPB_RESET   = 8'd221;

	localparam logic [8:0]  CHIRP_SPAN   = 9'd400;
	localparam logic [9:0]  CHIRP_HALF   = 10'd200;
	localparam logic [17:0] HOP_STEP     = 18'd800;
	localparam logic [14:0] QUARTER_TURN = 15'd16384;
	localparam logic [19:0] OUT_BIAS     = 20'd360448;
	localparam logic [15:0] RECIP_5      = 16'd52429;
	localparam int          RECIP_SHIFT  = 18;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 12'd102;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd2150;

	localparam logic [4:0] DIV_ITER_OFF = 5'd9;
	localparam logic [4:0] DIV_ITER_MOD = 5'd24;
	localparam logic [4:0] DIV_ITER_PH  = 5'd16;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [3:0] {
		OP_SETUP_OFF,
		OP_DIV_STEP,
		OP_FREQ,
		OP_MUL,
		OP_SETUP_MOD,
		OP_SETUP_PH,
		OP_ROM_A,
		OP_ROM_B,
		OP_INTERP,
		OP_SCALE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ACCEPT,
		COND_DIV_MORE,
		COND_FS_ZERO,
		COND_OUT_BLOCKED
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE      = 4'd0;
	localparam step_t STEP_DIV_OFF   = 4'd1;
	localparam step_t STEP_FREQ      = 4'd2;
	localparam step_t STEP_MUL       = 4'd3;
	localparam step_t STEP_SETUP_MOD = 4'd4;
	localparam step_t STEP_DIV_MOD   = 4'd5;
	localparam step_t STEP_SETUP_PH  = 4'd6;
	localparam step_t STEP_DIV_PH    = 4'd7;
	localparam step_t STEP_ROM_A     = 4'd8;
	localparam step_t STEP_ROM_B     = 4'd9;
	localparam step_t STEP_INTERP    = 4'd10;
	localparam step_t STEP_SCALE     = 4'd11;
	localparam step_t STEP_EMIT      = 4'd12;

	typedef struct packed {
		op_t   op;
		cond_t hold;
		cond_t jump;
		step_t target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:      w = '{OP_SETUP_OFF, COND_NO_ACCEPT, COND_NEVER, STEP_IDLE};
			STEP_DIV_OFF:   w = '{OP_DIV_STEP, COND_DIV_MORE, COND_NEVER, STEP_IDLE};
			STEP_FREQ:      w = '{OP_FREQ, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_MUL:       w = '{OP_MUL, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_SETUP_MOD: w = '{OP_SETUP_MOD, COND_NEVER, COND_FS_ZERO, STEP_ROM_A};
			STEP_DIV_MOD:   w = '{OP_DIV_STEP, COND_DIV_MORE, COND_NEVER, STEP_IDLE};
			STEP_SETUP_PH:  w = '{OP_SETUP_PH, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_DIV_PH:    w = '{OP_DIV_STEP, COND_DIV_MORE, COND_NEVER, STEP_IDLE};
			STEP_ROM_A:     w = '{OP_ROM_A, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_ROM_B:     w = '{OP_ROM_B, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_INTERP:    w = '{OP_INTERP, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_SCALE:     w = '{OP_SCALE, COND_NEVER, COND_NEVER, STEP_IDLE};
			STEP_EMIT:      w = '{OP_EMIT, COND_OUT_BLOCKED, COND_ALWAYS, STEP_IDLE};
			default:        w = '{OP_SETUP_OFF, COND_NEVER, COND_ALWAYS, STEP_IDLE};
		endcase
		return w;
	endfunction

	// Quarter-wave sine entry in Q16, from a Q30 Taylor series, rounded.
	function automatic logic [16:0] sin_q16(input longint unsigned k, input int tbits);
		longint unsigned x;
		longint unsigned term;
		longint sum;
		longint r;
		x = ((PI_Q30 >> 1) * k) >> tbits;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			unique case (n)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				6: term = term / 156;
				default: term = term / 210;
			endcase
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + 8192) >>> 14;
		if (r > 65536) begin
			r = 65536;
		end
		return r[16:0];
	endfunction

endpackage

>>> design/hopping_chirp_fsk_modulator_top.sv
// Top level of the hopping chirp FSK modulator with its microcoded sequencer.
// Ticks are taken one at a time: in_stall stays high from an accepted tick until its sample is emitted.
// With a zero sample rate the modulo and phase divisions are skipped.
// The shared divider retires one quotient bit per cycle.
// Reset restores the register defaults and clears the bit state; the sine ROM is constant.
`include "hopping_chirp_fsk_modulator_top_defines.svh"

module hopping_chirp_fsk_modulator_top
	import hcfm_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   data_bit,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_W-1:0]    sample,
	output logic                   bit_done
);

	localparam int TB        = SINE_TABLE_BITS;
	localparam int QTR_LEN   = 1 << TB;
	localparam int FRAC_BITS = 14 - TB;
	localparam int FRAC_W    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int LERP_W    = 17 + FRAC_W;
	localparam logic [TB:0] QTR_IDX = (TB+1)'(QTR_LEN);

	typedef logic [16:0] qtab_t [QTR_LEN+1];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int k = 0; k <= QTR_LEN; k++) begin
			t[k] = sin_q16(longint'(k), TB);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	logic [14:0] space_q;
	logic [14:0] mark_q;
	logic [17:0] fs_q;
	logic [7:0]  spb_q;

	logic [7:0] sample_index_q;
	logic       held_q;
	logic       zpar_q;
	logic       opar_q;

	step_t      step_q;
	step_t      step_d;
	logic [4:0] iter_q;
	ucode_t     uc;
	logic       hold_hit;
	logic       jump_hit;

	logic [7:0]         cnt_q;
	logic [7:0]         spb_eff_q;
	logic [17:0]        rem_q;
	logic [23:0]        dvd_q;
	logic [15:0]        quo_q;
	logic [17:0]        div_d_q;
	logic signed [17:0] f_q;
	logic signed [25:0] prod_q;
	logic               neg_q;
	logic               phase_zero_q;
	logic [TB:0]        idx_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               top_q;
	logic               sneg_q;
	logic [16:0]        a_q;
	logic [16:0]        rom_q;
	logic [16:0]        mag_q;
	logic [29:0]        scale_q;
	logic               out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic               bit_done_q;

	logic               in_accept;
	logic               out_blocked;
	logic [7:0]         spb_eff_c;
	logic [7:0]         cnt_c;
	logic               held_c;
	logic [16:0]        span_c;
	logic [18:0]        div_t_c;
	logic               div_ge_c;
	logic [18:0]        div_sub_c;
	logic signed [9:0]  off_c;
	logic signed [17:0] off_ext_c;
	logic signed [17:0] f_c;
	logic signed [26:0] prod_c;
	logic [25:0]        abs_c;
	logic [17:0]        ph_rem_c;
	logic [15:0]        phase_c;
	logic [14:0]        pos_c;
	logic [TB:0]        idx_c;
	logic [FRAC_W-1:0]  frac_c;
	logic [TB:0]        rom_addr_c;
	logic [16:0]        diff_c;
	logic [LERP_W-1:0]  lerp_c;
	logic [16:0]        mag_c;
	logic [19:0]        five_c;
	logic [19:0]        n_c;
	logic [29:0]        scale_c;
	logic               last_c;

	assign cfg_ready   = 1'b1;
	assign in_stall    = (step_q != STEP_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign out_blocked = out_valid_q && out_stall;
	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign bit_done    = bit_done_q;

	assign uc = ucode_rom(step_q);

	assign spb_eff_c = (spb_q == 8'd0) ? 8'd1 :
		((spb_q > 8'(SPB_MAX)) ? 8'(SPB_MAX) : spb_q);
	assign cnt_c  = (sample_index_q >= spb_eff_c) ? 8'd0 : sample_index_q;
	assign held_c = (cnt_c == 8'd0) ? data_bit : held_q;
	assign span_c = 17'(cnt_c) * 17'(CHIRP_SPAN);

	assign div_t_c   = {rem_q, dvd_q[23]};
	assign div_ge_c  = (div_t_c >= {1'b0, div_d_q});
	assign div_sub_c = div_t_c - {1'b0, div_d_q};

	assign off_c     = $signed({1'b0, quo_q[8:0]}) - $signed(CHIRP_HALF);
	assign off_ext_c = {{8{off_c[9]}}, off_c};
	assign f_c = (!held_q) ?
		($signed({3'b000, space_q}) + (zpar_q ? $signed(HOP_STEP) : 18'sd0) - off_ext_c) :
		($signed({3'b000, mark_q}) - (opar_q ? 18'sd0 : $signed(HOP_STEP)) + off_ext_c);

	assign prod_c   = f_q * $signed({1'b0, cnt_q});
	assign abs_c    = prod_q[25] ? 26'(-prod_q) : 26'(prod_q);
	assign ph_rem_c = (neg_q && (rem_q != 18'd0)) ? (fs_q - rem_q) : rem_q;

	assign phase_c = phase_zero_q ? 16'd0 : quo_q;
	assign pos_c   = phase_c[14] ? (QUARTER_TURN - {1'b0, phase_c[13:0]}) :
		{1'b0, phase_c[13:0]};
	assign idx_c   = pos_c[14:FRAC_BITS];
	assign frac_c  = (FRAC_BITS > 0) ? pos_c[FRAC_W-1:0] : '0;

	assign rom_addr_c = (uc.op == OP_ROM_B) ? (top_q ? QTR_IDX : (idx_q + 1'b1)) : idx_c;

	assign diff_c = rom_q - a_q;
	assign lerp_c = LERP_W'(diff_c) * LERP_W'(frac_q);
	assign mag_c  = a_q + 17'(lerp_c >> FRAC_BITS);

	assign five_c  = 20'({mag_q, 2'b00}) + 20'(mag_q);
	assign n_c     = sneg_q ? (OUT_BIAS - five_c) : (OUT_BIAS + five_c);
	assign scale_c = 30'(n_c[19:6]) * 30'(RECIP_5);

	assign last_c = (({1'b0, cnt_q} + 9'd1) == {1'b0, spb_eff_q});

	always_comb begin
		unique case (uc.hold)
			COND_NEVER:       hold_hit = 1'b0;
			COND_ALWAYS:      hold_hit = 1'b1;
			COND_NO_ACCEPT:   hold_hit = !in_accept;
			COND_DIV_MORE:    hold_hit = (iter_q > 5'd1);
			COND_FS_ZERO:     hold_hit = (fs_q == 18'd0);
			COND_OUT_BLOCKED: hold_hit = out_blocked;
			default:          hold_hit = 1'b0;
		endcase
		unique case (uc.jump)
			COND_NEVER:       jump_hit = 1'b0;
			COND_ALWAYS:      jump_hit = 1'b1;
			COND_NO_ACCEPT:   jump_hit = !in_accept;
			COND_DIV_MORE:    jump_hit = (iter_q > 5'd1);
			COND_FS_ZERO:     jump_hit = (fs_q == 18'd0);
			COND_OUT_BLOCKED: jump_hit = out_blocked;
			default:          jump_hit = 1'b0;
		endcase
		priority if (hold_hit) begin
			step_d = step_q;
		end else if (jump_hit) begin
			step_d = uc.target;
		end else begin
			step_d = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q        <= SPACE_RESET;
			mark_q         <= MARK_RESET;
			fs_q           <= FS_RESET;
			spb_q          <= SPB_RESET;
			step_q         <= STEP_IDLE;
			iter_q         <= 5'd0;
			out_valid_q    <= 1'b0;
			sample_index_q <= 8'd0;
			held_q         <= 1'b0;
			zpar_q         <= 1'b0;
			opar_q         <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SPACE: space_q <= cfg_data[14:0];
					CFG_MARK:  mark_q  <= cfg_data[14:0];
					CFG_FS:    fs_q    <= cfg_data[17:0];
					CFG_SPB:   spb_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (uc.op)
				OP_SETUP_OFF: begin
					if (in_accept) begin
						iter_q <= DIV_ITER_OFF;
						held_q <= held_c;
					end
				end
				OP_DIV_STEP:  iter_q <= iter_q - 5'd1;
				OP_SETUP_MOD: iter_q <= DIV_ITER_MOD;
				OP_SETUP_PH:  iter_q <= DIV_ITER_PH;
				OP_EMIT: begin
					if (!out_blocked) begin
						if (last_c) begin
							sample_index_q <= 8'd0;
							if (!held_q) begin
								zpar_q <= !zpar_q;
							end else begin
								opar_q <= !opar_q;
							end
						end else begin
							sample_index_q <= cnt_q + 8'd1;
						end
					end
				end
				default: ;
			endcase
			if ((uc.op == OP_EMIT) && !out_blocked) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= QTAB[rom_addr_c];
	end

	always_ff @(posedge clk) begin
		unique case (uc.op)
			OP_SETUP_OFF: begin
				if (in_accept) begin
					cnt_q     <= cnt_c;
					spb_eff_q <= spb_eff_c;
					rem_q     <= {10'd0, span_c[16:9]};
					dvd_q     <= {span_c[8:0], 15'd0};
					quo_q     <= 16'd0;
					div_d_q   <= {10'd0, spb_eff_c};
				end
			end
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[22:0], 1'b0};
				if (div_ge_c) begin
					rem_q <= div_sub_c[17:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= div_t_c[17:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
			end
			OP_FREQ: f_q <= f_c;
			OP_MUL:  prod_q <= prod_c[25:0];
			OP_SETUP_MOD: begin
				phase_zero_q <= (fs_q == 18'd0);
				neg_q        <= prod_q[25];
				rem_q        <= 18'd0;
				dvd_q        <= abs_c[23:0];
				div_d_q      <= fs_q;
			end
			OP_SETUP_PH: begin
				rem_q <= ph_rem_c;
				dvd_q <= 24'd0;
				quo_q <= 16'd0;
			end
			OP_ROM_A: begin
				idx_q  <= idx_c;
				frac_q <= frac_c;
				top_q  <= idx_c[TB];
				sneg_q <= phase_c[15];
			end
			OP_ROM_B:  a_q <= rom_q;
			OP_INTERP: mag_q <= mag_c;
			OP_SCALE:  scale_q <= scale_c;
			OP_EMIT: begin
				if (!out_blocked) begin
					sample_q   <= scale_q[RECIP_SHIFT +: SAMPLE_W];
					bit_done_q <= last_c;
				end
			end
			default: ;
		endcase
	end

	`HCFM_ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall, "busy flag missed after a transfer")
	`HCFM_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_q), $past(step_q) == STEP_EMIT, "result shown outside the emit step")
	`HCFM_ASSERT_IMPL(a_div_rem_bound, uc.op == OP_DIV_STEP, rem_q < div_d_q, "divider remainder not below divisor")
	`HCFM_ASSERT_IMPL(a_sample_range, out_valid_q, (sample_q >= SAMPLE_MIN) && (sample_q <= SAMPLE_MAX), "sample code out of range")

endmodule
